FILE: design/mexp_pkg.sv
// shared types and constants of the modular exponentiation block
package mexp_pkg;

    // exponent bits scanned per request
    localparam int EXP_BITS = 32;
    localparam int CNT_W    = $clog2(EXP_BITS);

    // destination of a product traveling down the cell row
    localparam logic TAG_R = 1'b0;   // running result
    localparam logic TAG_Y = 1'b1;   // running square

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_INIT = 6'b000010,
        S_MUL  = 6'b000100,
        S_SQR  = 6'b001000,
        S_WAIT = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    typedef struct packed {
        logic valid;
        logic tag;
    } t_cell_ctl;

endpackage

FILE: design/mexp_cell.sv
// one cell of the modular multiplier row: one multiplier bit per cell
module mexp_cell
    import mexp_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [WIDTH-1:0] i_n,
    input  t_cell_ctl        i_ctl,
    input  logic [WIDTH-1:0] i_r,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    output t_cell_ctl        o_ctl,
    output logic [WIDTH-1:0] o_r,
    output logic [WIDTH-1:0] o_a,
    output logic [WIDTH-1:0] o_b
);

    t_cell_ctl        r_ctl;
    logic [WIDTH-1:0] r_r;
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_b;

    logic [WIDTH+1:0] w_sum;
    logic [WIDTH+1:0] w_n1;
    logic [WIDTH+1:0] w_n2;
    logic [WIDTH+1:0] w_sub1;
    logic [WIDTH+1:0] w_sub2;
    logic [WIDTH-1:0] n_r;

    // 2r + bit*a stays below 3n, so at most two subtractions of n
    always_comb begin
        w_sum  = {1'b0, i_r, 1'b0} + (i_b[WIDTH-1] ? {2'b00, i_a} : '0);
        w_n1   = {2'b00, i_n};
        w_n2   = {1'b0, i_n, 1'b0};
        w_sub1 = w_sum - w_n1;
        w_sub2 = w_sum - w_n2;
        if (w_sum >= w_n2) begin
            n_r = w_sub2[WIDTH-1:0];
        end else if (w_sum >= w_n1) begin
            n_r = w_sub1[WIDTH-1:0];
        end else begin
            n_r = w_sum[WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r <= n_r;
        r_a <= i_a;
        r_b <= {i_b[WIDTH-2:0], 1'b0};
    end

    assign o_ctl = r_ctl;
    assign o_r   = r_r;
    assign o_a   = r_a;
    assign o_b   = r_b;

endmodule

FILE: design/modular_exponentiation_32.sv
// top level: base to a 32-bit exponent modulo a configured odd modulus
//
// returns o_result_value = i_base_value ^ i_exponent mod N, fully reduced, with
// N the odd modulus loaded through i_cfg_we / i_cfg_wdata (reset value 1). the
// exponent is scanned right to left over all 32 bits: for each bit the running
// result is multiplied by the running square when the bit is set, then the square
// is squared. every modular product runs down a row of WIDTH identical cells, one
// multiplier bit per cell, MSB first (double, add, reduce by at most two
// subtractions of N). the result product and the square product enter the row in
// consecutive cycles and travel together; the first pass through the row reduces
// the base modulo N. one request is worked on at a time: i_in_valid is taken only
// while the engine is idle, and the finished result sits in an output register so
// the next request may start before it is taken. an even modulus (zero included)
// gives o_modulus_error = 1 and a result of 0 without entering the cell row.
// the modulus and base are used in their low WIDTH bits; the modulus may only be
// written while no request is outstanding
module modular_exponentiation_32
    import mexp_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_base_value,
    input  logic [31:0] i_exponent,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_result_value,
    output logic        o_modulus_error
);

    t_state              r_state;
    logic [31:0]         r_modulus;
    logic [EXP_BITS-1:0] r_exp;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_init_done;
    logic [WIDTH-1:0]    r_base;
    logic [WIDTH-1:0]    r_r;
    logic [WIDTH-1:0]    r_y;
    logic                r_err;

    logic                r_out_valid;
    logic [31:0]         r_out_result;
    logic                r_out_err;

    logic [WIDTH-1:0]    w_n;
    logic [WIDTH-1:0]    w_one;
    logic                w_in_acc;

    // operands launched into the first cell
    t_cell_ctl           w_launch_ctl;
    logic [WIDTH-1:0]    w_launch_a;
    logic [WIDTH-1:0]    w_launch_b;

    // cell row wiring, entry 0 is the launch point
    t_cell_ctl           w_ctl [0:WIDTH];
    logic [WIDTH-1:0]    w_r   [0:WIDTH];
    logic [WIDTH-1:0]    w_a   [0:WIDTH];
    logic [WIDTH-1:0]    w_b   [0:WIDTH];

    assign w_n      = WIDTH'(r_modulus);
    // 1 mod n, zero when n is one
    assign w_one    = (w_n == WIDTH'(1)) ? '0 : WIDTH'(1);
    assign w_in_acc = i_in_valid && o_in_ready;

    // modulus register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= 32'd1;
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_wdata;
        end
    end

    // launch into the cell row: base reduction, result product, square product
    always_comb begin
        w_launch_ctl = '0;
        w_launch_a   = r_y;
        w_launch_b   = r_y;
        case (r_state)
            S_INIT: begin
                w_launch_ctl = '{valid: 1'b1, tag: TAG_Y};
                w_launch_a   = w_one;
                w_launch_b   = r_base;
            end
            S_MUL: begin
                w_launch_ctl = '{valid: r_exp[0], tag: TAG_R};
                w_launch_a   = r_r;
                w_launch_b   = r_y;
            end
            S_SQR: begin
                w_launch_ctl = '{valid: 1'b1, tag: TAG_Y};
            end
            default: begin
                w_launch_ctl = '0;
            end
        endcase
    end

    // every product starts from a zero partial result
    assign w_ctl[0] = w_launch_ctl;
    assign w_r[0]   = '0;
    assign w_a[0]   = w_launch_a;
    assign w_b[0]   = w_launch_b;

    for (genvar g = 0; g < WIDTH; g++) begin : g_cell
        mexp_cell #(
            .WIDTH (WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_n     (w_n),
            .i_ctl   (w_ctl[g]),
            .i_r     (w_r[g]),
            .i_a     (w_a[g]),
            .i_b     (w_b[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_r     (w_r[g+1]),
            .o_a     (w_a[g+1]),
            .o_b     (w_b[g+1])
        );
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_init_done <= 1'b0;
            r_cnt       <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_cnt       <= '0;
                        r_init_done <= 1'b0;
                        r_state     <= w_n[0] ? S_INIT : S_OUT;
                    end
                end
                S_INIT: begin
                    r_state <= S_WAIT;
                end
                S_MUL: begin
                    r_state <= S_SQR;
                end
                S_SQR: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    // the square leaves the row last, so it closes the step
                    if (w_ctl[WIDTH].valid && w_ctl[WIDTH].tag == TAG_Y) begin
                        if (!r_init_done) begin
                            r_init_done <= 1'b1;
                            r_state     <= S_MUL;
                        end else if (r_cnt == CNT_W'(EXP_BITS - 1)) begin
                            r_state <= S_OUT;
                        end else begin
                            r_cnt   <= r_cnt + CNT_W'(1);
                            r_state <= S_MUL;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_in_acc) begin
            r_base <= WIDTH'(i_base_value);
            r_exp  <= i_exponent;
            r_err  <= !w_n[0];
        end
        if (r_state == S_INIT) begin
            r_r <= w_one;
        end
        if (w_ctl[WIDTH].valid) begin
            if (w_ctl[WIDTH].tag == TAG_R) begin
                r_r <= w_r[WIDTH];
            end else begin
                r_y <= w_r[WIDTH];
            end
        end
        // next exponent bit once a step's square is back
        if (r_state == S_WAIT && r_init_done && w_ctl[WIDTH].valid &&
            w_ctl[WIDTH].tag == TAG_Y) begin
            r_exp <= {1'b0, r_exp[EXP_BITS-1:1]};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && (!r_out_valid || i_out_ready)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_out_valid || i_out_ready)) begin
            r_out_result <= r_err ? 32'd0 : 32'(r_r);
            r_out_err    <= r_err;
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_result_value  = r_out_result;
    assign o_modulus_error = r_out_err;

`ifndef SYNTH
    // products only leave the cell row while the sequencer waits for them
    a_row_out_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl[WIDTH].valid |-> r_state == S_WAIT)
        else $error("product left the cell row outside the wait state");

    // an accepted request always starts the engine
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_state != S_IDLE)
        else $error("accepted request did not start the engine");

    // an error result carries zero
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_modulus_error) |-> o_result_value == 32'd0)
        else $error("modulus error with nonzero result");

    // a good result is fully reduced
    a_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_modulus_error) |-> WIDTH'(o_result_value) < w_n)
        else $error("result not below the modulus");
`endif

endmodule

FILE: test/tb.sv
// testbench of modular_exponentiation_32: random and directed requests checked against a predictor
`timescale 1ns / 100ps

typedef struct packed {
    logic [31:0] result_value;
    logic        modulus_error;
} t_power_result;

class power_scoreboard;
    logic [31:0]   modulus = 32'd1;
    t_power_result pending_powers[$];
    int            mismatches = 0;

    // base ^ exponent mod modulus, square-and-multiply over all exponent bits
    function t_power_result predict_power(logic [31:0] base, logic [31:0] exponent);
        t_power_result res;
        bit [63:0]     n;
        bit [63:0]     acc;
        bit [63:0]     sq;
        n = {32'd0, modulus};
        if (!n[0]) begin
            res.result_value  = 32'd0;
            res.modulus_error = 1'b1;
            return res;
        end
        acc = 64'd1 % n;
        sq  = {32'd0, base} % n;
        for (int i = 0; i < 32; i++) begin
            if (exponent[i]) acc = (acc * sq) % n;
            sq = (sq * sq) % n;
        end
        res.result_value  = acc[31:0];
        res.modulus_error = 1'b0;
        return res;
    endfunction

    function void note_request(logic [31:0] base, logic [31:0] exponent);
        pending_powers.push_back(predict_power(base, exponent));
    endfunction

    function void check_result(logic [31:0] value, logic err);
        t_power_result want;
        if (pending_powers.size() == 0) begin
            $display("%0t: unexpected result %h error %b", $time, value, err);
            mismatches++;
            return;
        end
        want = pending_powers.pop_front();
        if (value !== want.result_value) begin
            $display("%0t: result_value expected %h got %h", $time,
                     want.result_value, value);
            mismatches++;
        end
        if (err !== want.modulus_error) begin
            $display("%0t: modulus_error expected %b got %b", $time,
                     want.modulus_error, err);
            mismatches++;
        end
    endfunction
endclass

module tb;
    import mexp_pkg::*;

    // idle cycles without any handshake before the run is declared hung
    localparam int HANG_LIMIT = 20000;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic [31:0] i_cfg_wdata     = 32'd0;
    logic        i_in_valid      = 1'b0;
    logic [31:0] i_base_value    = 32'd0;
    logic [31:0] i_exponent      = 32'd0;
    logic        i_out_ready     = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [31:0] o_result_value;
    logic        o_modulus_error;

    power_scoreboard book = new();

    // gaps on both sides switch on and off per phase
    logic idle_on    = 1'b0;
    int   stall_left = 0;
    int   idle_cycles = 0;

    modular_exponentiation_32 uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_base_value   (i_base_value),
        .i_exponent     (i_exponent),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_value (o_result_value),
        .o_modulus_error(o_modulus_error)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return $urandom_range(0, 3);
        else if (roll < 95) return $urandom_range(4, 24);
        else return $urandom_range(60, 300);
    endfunction

    // result side back-pressure
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= pick_gap();
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // handshake monitor: values seen here are the ones present before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) book.note_request(i_base_value, i_exponent);
            if (o_out_valid && i_out_ready) book.check_result(o_result_value, o_modulus_error);
        end
    end

    // watchdog: ends a hung run, reporting mismatches
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= HANG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one request: optional gap with valid low, then hold until accepted
    task automatic send_request(input logic [31:0] base, input logic [31:0] exponent);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_base_value <= base;
        i_exponent   <= exponent;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // stop sending and let every outstanding request come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (book.pending_powers.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // modulus write, only with the engine idle
    task automatic set_modulus(input logic [31:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        book.modulus = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mostly odd moduli of all sizes, now and then even or one
    function automatic logic [31:0] pick_modulus();
        int roll;
        roll = $urandom_range(0, 9);
        case (roll)
            0: begin
                return $urandom & 32'hFFFF_FFFE;
            end
            1: begin
                return 32'd1;
            end
            2, 3: begin
                return $urandom_range(3, 255) | 32'd1;
            end
            4, 5: begin
                return $urandom_range(32'hFFFF_FF00, 32'hFFFF_FFFF) | 32'd1;
            end
            default: begin
                return $urandom | 32'd1;
            end
        endcase
    endfunction

    task automatic random_requests(input int count);
        logic [31:0] base;
        logic [31:0] exponent;
        int          roll;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 60) base = $urandom;
            else if (roll < 75) base = $urandom_range(0, 15);
            else if (roll < 85) base = book.modulus;
            else if (roll < 95) base = book.modulus - 32'd1;
            else base = 32'hFFFF_FFFF;
            roll = $urandom_range(0, 99);
            if (roll < 65) exponent = $urandom;
            else if (roll < 80) exponent = $urandom_range(0, 31);
            else if (roll < 88) exponent = 32'd1 << $urandom_range(0, 31);
            else if (roll < 94) exponent = 32'd0;
            else exponent = 32'hFFFF_FFFF;
            send_request(base, exponent);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset modulus is one: everything reduces to zero
        send_request(32'd5, 32'd0);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // largest odd modulus, field extremes
        idle_on <= 1'b1;
        set_modulus(32'hFFFF_FFFF);
        send_request(32'd0, 32'd0);
        send_request(32'd0, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'd0);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFE, 32'd2);
        send_request(32'd2, 32'd31);
        send_request(32'd12345, 32'd1);

        // modulus one written explicitly
        set_modulus(32'd1);
        send_request(32'd7, 32'd0);
        send_request(32'd0, 32'd0);

        // smallest odd modulus above one, base at and past the modulus
        set_modulus(32'd3);
        send_request(32'd3, 32'd5);
        send_request(32'd7, 32'd2);
        send_request(32'h8000_0000, 32'h8000_0000);

        // even moduli, zero included, flag the error
        set_modulus(32'd0);
        send_request(32'd5, 32'd5);
        send_request(32'd0, 32'd0);
        set_modulus(32'hFFFF_FFFE);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        set_modulus(32'd2);
        send_request(32'd1, 32'd1);

        // top bit set in the modulus, base equal to it and just below it
        set_modulus(32'h8000_0001);
        send_request(32'h8000_0001, 32'd7);
        send_request(32'h8000_0000, 32'hFFFF_FFFF);

        // random phases, every third one with no idling at all
        for (int p = 0; p < 12; p++) begin
            idle_on <= (p % 3 != 0);
            set_modulus(pick_modulus());
            random_requests(21);
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (book.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
